// File: rtl/core/dvtu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the distance vector table update block.
// Used by dvtu_ctrl, dvtu_datapath and distance_vector_table_update; depends on nothing.

package dvtu_pkg;

  // Table geometry and distance encoding.
  localparam int NODE_W     = 4;
  localparam int MAX_NODES  = 1 << NODE_W;
  localparam int ADDR_W     = 2 * NODE_W;
  localparam int DIST_WIDTH = 8;
  localparam int NUM_W      = 5;
  localparam int CNT_W      = 5;
  localparam int KIND_W     = 2;

  typedef logic [DIST_WIDTH-1:0] dist_t;
  typedef logic [NODE_W-1:0]     node_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  localparam dist_t DIST_UNREACH = '1;
  localparam dist_t DIST_SAT     = DIST_UNREACH - dist_t'(1);
  localparam logic [NUM_W-1:0] NUM_NODES_RST = NUM_W'(MAX_NODES);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_EDGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADV  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // Channel payloads.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    node_t             node_a;
    node_t             node_b;
  } in_item_t;

  typedef struct packed {
    logic             reachable;
    dist_t            distance;
    node_t            next_hop;
    logic [CNT_W-1:0] entries_changed;
  } out_item_t;

  // One routing table entry as stored in memory.
  typedef struct packed {
    dist_t metric;
    node_t hop;
  } entry_t;

  // Read port usage and write source selected by the controller.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_ITEM,
    RD_SCAN
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_AB,
    WR_BA
  } wr_sel_t;

  typedef struct packed {
    logic    latch_item;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    cnt_inc;
    logic    cost_ld;
    logic    res_ld;
  } ctrl_cmd_t;

  typedef struct packed {
    logic              item_ok;
    logic [KIND_W-1:0] kind;
    logic              same_node;
    logic              cost_unreach;
    logic              scan_last;
    logic              out_busy;
  } ctrl_stat_t;

  // Value an entry holds before it is first written.
  function automatic entry_t reset_entry(addr_t addr);
    entry_t e;
    if (addr[ADDR_W-1:NODE_W] == addr[NODE_W-1:0]) begin
      e.metric = '0;
      e.hop    = addr[ADDR_W-1:NODE_W];
    end else begin
      e.metric = DIST_UNREACH;
      e.hop    = '0;
    end
    return e;
  endfunction

endpackage

// File: rtl/core/distance_vector_table_update.sv
`timescale 1ns / 1ps
// Top level of the distance vector table update block.
// Instantiates dvtu_ctrl and dvtu_datapath; depends on dvtu_pkg.

// Keeps a distance and next hop table for each of up to 16 nodes and applies
// edge, advertisement and read transactions one at a time, returning one result
// transaction for each. An advertisement scans the nodes in use, reading one
// destination of the source and receiver rows per cycle through the two read
// ports of the table memory. An advertisement whose source cannot reach the
// receiver ends without a scan. The result sits in an output register, so the
// next transaction is accepted while the previous result waits. Entries hold
// their reset routes through per-entry valid bits, so no clearing pass follows
// reset. The node count register may be written whenever the block is idle;
// cfg_ready is always high.

module distance_vector_table_update (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dvtu_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dvtu_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dvtu_pkg::NUM_W-1:0] cfg_data
);

  dvtu_pkg::ctrl_cmd_t  cmd;
  dvtu_pkg::ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  dvtu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Table storage and arithmetic.
  dvtu_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: rtl/core/dvtu_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine for the distance vector table update block.
// Depends on dvtu_pkg for the command and status structs and the item kinds.

module dvtu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dvtu_pkg::ctrl_stat_t stat,
  output dvtu_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EDGE_B,
    S_COST,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cmd.latch_item = 1'b0;
    cmd.rd_sel     = dvtu_pkg::RD_NONE;
    cmd.wr_sel     = dvtu_pkg::WR_NONE;
    cmd.cnt_inc    = 1'b0;
    cmd.cost_ld    = 1'b0;
    cmd.res_ld     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        if (stat.item_ok) begin
          if (stat.kind == dvtu_pkg::KIND_EDGE && !stat.same_node) begin
            cmd.wr_sel = dvtu_pkg::WR_AB;
            state_next = S_EDGE_B;
          end else if (stat.kind == dvtu_pkg::KIND_READ) begin
            cmd.rd_sel = dvtu_pkg::RD_ITEM;
          end else if (stat.kind == dvtu_pkg::KIND_ADV && !stat.same_node) begin
            cmd.rd_sel = dvtu_pkg::RD_ITEM;
            state_next = S_COST;
          end
        end
      end
      S_EDGE_B: begin
        cmd.wr_sel = dvtu_pkg::WR_BA;
        state_next = S_FINISH;
      end
      S_COST: begin
        cmd.cost_ld = 1'b1;
        state_next  = stat.cost_unreach ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_sel  = dvtu_pkg::RD_SCAN;
        cmd.cnt_inc = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last destination is compared and written in this cycle.
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.res_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/dvtu_datapath.sv
`timescale 1ns / 1ps
// Datapath: route table memory, valid bits, item and config registers,
// relaxation compare and output register. Depends on dvtu_pkg.

module dvtu_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  dvtu_pkg::in_item_t             in_data,
  input  logic                           cfg_valid,
  input  logic [dvtu_pkg::NUM_W-1:0]     cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output dvtu_pkg::out_item_t            out_data,
  input  dvtu_pkg::ctrl_cmd_t            cmd,
  output dvtu_pkg::ctrl_stat_t           stat
);

  localparam int TABLE_SIZE = dvtu_pkg::MAX_NODES * dvtu_pkg::MAX_NODES;

  dvtu_pkg::in_item_t            item;
  logic [dvtu_pkg::NUM_W-1:0]    num_nodes;
  logic [dvtu_pkg::NUM_W-1:0]    n_use;
  logic [dvtu_pkg::NUM_W-1:0]    n_last;
  dvtu_pkg::node_t               idx;
  dvtu_pkg::node_t               pend_idx;
  logic                          pend;
  dvtu_pkg::dist_t               cost;
  logic [dvtu_pkg::CNT_W-1:0]    changed;

  dvtu_pkg::entry_t              mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0]         vbit;

  dvtu_pkg::addr_t               rd_addr0;
  dvtu_pkg::addr_t               rd_addr1;
  dvtu_pkg::addr_t               rd_q_addr0;
  dvtu_pkg::addr_t               rd_q_addr1;
  dvtu_pkg::entry_t              rd_q0;
  dvtu_pkg::entry_t              rd_q1;
  logic                          rd_v0;
  logic                          rd_v1;
  dvtu_pkg::entry_t              ent0;
  dvtu_pkg::entry_t              ent1;

  logic [dvtu_pkg::DIST_WIDTH:0] sum;
  dvtu_pkg::dist_t               cand;
  logic                          take;

  logic                          wr_en;
  dvtu_pkg::addr_t               wr_addr;
  dvtu_pkg::entry_t              wr_data;

  dvtu_pkg::out_item_t           res;

  // Nodes in use, clamped to the table size.
  always_comb begin
    if (num_nodes > dvtu_pkg::NUM_NODES_RST) begin
      n_use = dvtu_pkg::NUM_NODES_RST;
    end else begin
      n_use = num_nodes;
    end
    n_last = n_use - dvtu_pkg::NUM_W'(1);
  end

  // Status for the controller.
  always_comb begin
    stat.item_ok      = ({1'b0, item.node_a} < n_use) && ({1'b0, item.node_b} < n_use);
    stat.kind         = item.kind;
    stat.same_node    = (item.node_a == item.node_b);
    stat.cost_unreach = (ent0.metric == dvtu_pkg::DIST_UNREACH);
    stat.scan_last    = (idx == n_last[dvtu_pkg::NODE_W-1:0]);
    stat.out_busy     = out_valid && !out_ready;
  end

  // Configuration register and control flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes <= dvtu_pkg::NUM_NODES_RST;
      pend      <= 1'b0;
      vbit      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        num_nodes <= cfg_data;
      end
      pend <= (cmd.rd_sel == dvtu_pkg::RD_SCAN);
      if (wr_en) begin
        vbit[wr_addr] <= 1'b1;
      end
      if (cmd.res_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item, scan index, cost and change count.
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item    <= in_data;
      idx     <= '0;
      changed <= '0;
    end else begin
      if (cmd.cnt_inc) begin
        idx <= idx + dvtu_pkg::NODE_W'(1);
      end
      if (take) begin
        changed <= changed + dvtu_pkg::CNT_W'(1);
      end
    end
    if (cmd.cost_ld) begin
      cost <= ent0.metric;
    end
    pend_idx <= idx;
  end

  // Read addresses: the item's entry, or the source and receiver rows at the scan index.
  always_comb begin
    if (cmd.rd_sel == dvtu_pkg::RD_ITEM) begin
      rd_addr0 = {item.node_a, item.node_b};
    end else begin
      rd_addr0 = {item.node_a, idx};
    end
    rd_addr1 = {item.node_b, idx};
  end

  // Table memory with two registered read ports and one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd_sel != dvtu_pkg::RD_NONE) begin
      rd_q0      <= mem[rd_addr0];
      rd_q1      <= mem[rd_addr1];
      rd_v0      <= vbit[rd_addr0];
      rd_v1      <= vbit[rd_addr1];
      rd_q_addr0 <= rd_addr0;
      rd_q_addr1 <= rd_addr1;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entries never written read as their reset value.
  assign ent0 = rd_v0 ? rd_q0 : dvtu_pkg::reset_entry(rd_q_addr0);
  assign ent1 = rd_v1 ? rd_q1 : dvtu_pkg::reset_entry(rd_q_addr1);

  // Relaxation: candidate distance through the source, saturated.
  always_comb begin
    sum = {1'b0, ent0.metric} + {1'b0, cost};
    if (sum > {1'b0, dvtu_pkg::DIST_SAT}) begin
      cand = dvtu_pkg::DIST_SAT;
    end else begin
      cand = sum[dvtu_pkg::DIST_WIDTH-1:0];
    end
    take = pend && (pend_idx != item.node_b) && (ent0.metric != dvtu_pkg::DIST_UNREACH) &&
           ((ent1.metric == dvtu_pkg::DIST_UNREACH) || (cand < ent1.metric) ||
            ((cand == ent1.metric) && (item.node_a < ent1.hop)));
  end

  // Write port source: edge entries or an improved route.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {item.node_b, pend_idx};
    wr_data = '{metric: cand, hop: item.node_a};
    case (cmd.wr_sel)
      dvtu_pkg::WR_AB: begin
        wr_en   = 1'b1;
        wr_addr = {item.node_a, item.node_b};
        wr_data = '{metric: dvtu_pkg::dist_t'(1), hop: item.node_b};
      end
      dvtu_pkg::WR_BA: begin
        wr_en   = 1'b1;
        wr_addr = {item.node_b, item.node_a};
        wr_data = '{metric: dvtu_pkg::dist_t'(1), hop: item.node_a};
      end
      default: begin
        wr_en = take;
      end
    endcase
  end

  // Result of the current item.
  always_comb begin
    res = '0;
    if (stat.item_ok) begin
      if (item.kind == dvtu_pkg::KIND_READ && ent0.metric != dvtu_pkg::DIST_UNREACH) begin
        res.reachable = 1'b1;
        res.distance  = ent0.metric;
        res.next_hop  = ent0.hop;
      end else if (item.kind == dvtu_pkg::KIND_ADV) begin
        res.entries_changed = changed;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      out_data <= res;
    end
  end

endmodule
